### hw/rtl/udqs_pkg.sv
// udqs_pkg: shared types, character constants and helpers for the url decode
// and query splitter; no dependencies, compiled first
package udqs_pkg;

    localparam int MAX_RESULTS = 3;
    localparam int FIFO_DEPTH_DEFAULT = 4;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [7:0] MAX_PAIRS_RESET = 8'd10;
    localparam logic [0:0] REG_MAX_PAIRS = 1'b0;

    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_QUESTION = 8'h3f;
    localparam logic [7:0] CHAR_EQUALS = 8'h3d;
    localparam logic [7:0] CHAR_AMP = 8'h26;

    typedef enum logic [2:0] {
        KIND_PATH     = 3'd0,
        KIND_KEY      = 3'd1,
        KIND_VALUE    = 3'd2,
        KIND_RESTART  = 3'd3,
        KIND_PAIR_END = 3'd4,
        KIND_DONE     = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        REGION_PATH  = 2'd0,
        REGION_QUERY = 2'd1,
        REGION_SKIP  = 2'd2
    } region_t;

    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_HIGH = 2'd1,
        ESC_LOW  = 2'd2
    } esc_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  out_byte;
        logic [7:0]  pair_index;
        logic [7:0]  pairs_found;
        logic        bad_escape;
        logic        last;
    } result_t;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] t;
        begin
            t = 8'd0;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                t = c - 8'h30;
            end
            else if (c >= 8'h61 && c <= 8'h66)
            begin
                t = c - 8'h57;
            end
            else if (c >= 8'h41 && c <= 8'h46)
            begin
                t = c - 8'h37;
            end
            return t[3:0];
        end
    endfunction

endpackage

### hw/rtl/udqs_ifs.sv
// udqs_ifs: valid/ready stream interfaces for url bytes and parse results
// no dependencies
interface udqs_url_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_last;

    modport source(output valid, output in_byte, output is_last, input ready);
    modport sink(input valid, input in_byte, input is_last, output ready);
endinterface

interface udqs_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic [7:0] pair_index;
    logic [7:0] pairs_found;
    logic       bad_escape;
    logic       last;

    modport source(output valid, output kind, output out_byte, output pair_index,
                   output pairs_found, output bad_escape, output last, input ready);
    modport sink(input valid, input kind, input out_byte, input pair_index,
                 input pairs_found, input bad_escape, input last, output ready);
endinterface

### hw/rtl/udqs_parser.sv
// udqs_parser: running parse state and per-byte decode into up to three results
// depends on udqs_pkg
module udqs_parser (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          take,
    input  logic [7:0]                                    in_byte,
    input  logic                                          is_last,
    input  logic [7:0]                                    max_pairs,
    output udqs_pkg::result_t [udqs_pkg::MAX_RESULTS-1:0] res,
    output logic [1:0]                                    res_count
);

    udqs_pkg::region_t region_reg, region_next;
    udqs_pkg::esc_t    esc_reg, esc_next;
    logic              key_closed_reg, key_closed_next;
    logic              value_open_reg, value_open_next;
    logic [3:0]        high_reg, high_next;
    logic [7:0]        count_reg, count_next;

    logic              have;
    logic [7:0]        d;
    logic              v0, v1, v2;
    logic              bad;
    udqs_pkg::result_t e0, e1, e2;

    always_comb
    begin
        region_next = region_reg;
        esc_next = esc_reg;
        key_closed_next = key_closed_reg;
        value_open_next = value_open_reg;
        high_next = high_reg;
        count_next = count_reg;
        have = 1'b0;
        d = 8'd0;
        v0 = 1'b0;
        v1 = 1'b0;
        v2 = 1'b0;
        e0 = '0;
        e1 = '0;
        e2 = '0;
        bad = 1'b0;

        if (region_reg != udqs_pkg::REGION_SKIP)
        begin
            if (esc_reg == udqs_pkg::ESC_HIGH)
            begin
                high_next = udqs_pkg::hex_value(in_byte);
                esc_next = udqs_pkg::ESC_LOW;
            end
            else if (esc_reg == udqs_pkg::ESC_LOW)
            begin
                d = {high_reg, udqs_pkg::hex_value(in_byte)};
                esc_next = udqs_pkg::ESC_NONE;
                have = 1'b1;
            end
            else if (in_byte == udqs_pkg::CHAR_PERCENT)
            begin
                esc_next = udqs_pkg::ESC_HIGH;
            end
            else if (region_reg == udqs_pkg::REGION_PATH)
            begin
                if (in_byte == udqs_pkg::CHAR_QUESTION)
                begin
                    region_next = (max_pairs != 8'd0) ? udqs_pkg::REGION_QUERY
                                                      : udqs_pkg::REGION_SKIP;
                end
                else
                begin
                    d = in_byte;
                    have = 1'b1;
                end
            end
            else if (in_byte == udqs_pkg::CHAR_EQUALS)
            begin
                key_closed_next = 1'b1;
                value_open_next = 1'b1;
                v0 = 1'b1;
                e0.kind = udqs_pkg::KIND_RESTART;
                e0.pair_index = count_reg;
            end
            else if (in_byte == udqs_pkg::CHAR_AMP)
            begin
                if (value_open_reg)
                begin
                    v0 = 1'b1;
                    e0.kind = udqs_pkg::KIND_PAIR_END;
                    e0.pair_index = count_reg;
                    count_next = count_reg + 8'd1;
                    key_closed_next = 1'b0;
                    value_open_next = 1'b0;
                    if (count_next >= max_pairs)
                    begin
                        region_next = udqs_pkg::REGION_SKIP;
                    end
                end
                else
                begin
                    key_closed_next = 1'b1;
                end
            end
            else
            begin
                d = in_byte;
                have = 1'b1;
            end

            if (have)
            begin
                e0.out_byte = d;
                if (region_next == udqs_pkg::REGION_PATH)
                begin
                    v0 = 1'b1;
                    e0.kind = udqs_pkg::KIND_PATH;
                end
                else if (region_next == udqs_pkg::REGION_QUERY && value_open_next)
                begin
                    v0 = 1'b1;
                    e0.kind = udqs_pkg::KIND_VALUE;
                    e0.pair_index = count_next;
                end
                else if (region_next == udqs_pkg::REGION_QUERY && !key_closed_next)
                begin
                    v0 = 1'b1;
                    e0.kind = udqs_pkg::KIND_KEY;
                    e0.pair_index = count_next;
                end
            end
        end

        bad = (region_next != udqs_pkg::REGION_SKIP) && (esc_next != udqs_pkg::ESC_NONE);

        if (is_last)
        begin
            if (region_next == udqs_pkg::REGION_QUERY && value_open_next)
            begin
                v1 = 1'b1;
                e1.kind = udqs_pkg::KIND_PAIR_END;
                e1.pair_index = count_next;
                count_next = count_next + 8'd1;
            end
            v2 = 1'b1;
            e2.kind = udqs_pkg::KIND_DONE;
            e2.pairs_found = count_next;
            e2.bad_escape = bad;
            e2.last = 1'b1;
            region_next = udqs_pkg::REGION_PATH;
            esc_next = udqs_pkg::ESC_NONE;
            key_closed_next = 1'b0;
            value_open_next = 1'b0;
            high_next = 4'd0;
            count_next = 8'd0;
        end
    end

    // pack the produced results into the low slots
    always_comb
    begin
        res[0] = v0 ? e0 : (v1 ? e1 : e2);
        res[1] = v0 ? (v1 ? e1 : e2) : e2;
        res[2] = e2;
        res_count = {1'b0, v0} + {1'b0, v1} + {1'b0, v2};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_reg <= udqs_pkg::REGION_PATH;
            esc_reg <= udqs_pkg::ESC_NONE;
            key_closed_reg <= 1'b0;
            value_open_reg <= 1'b0;
            high_reg <= 4'd0;
            count_reg <= 8'd0;
        end
        else if (take)
        begin
            region_reg <= region_next;
            esc_reg <= esc_next;
            key_closed_reg <= key_closed_next;
            value_open_reg <= value_open_next;
            high_reg <= high_next;
            count_reg <= count_next;
        end
    end

endmodule

### hw/rtl/udqs_result_fifo.sv
// udqs_result_fifo: small register queue that takes up to three results per cycle
// and presents one beat per cycle while pop is held; depends on udqs_pkg
module udqs_result_fifo #(
    parameter int DEPTH = udqs_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  udqs_pkg::result_t [udqs_pkg::MAX_RESULTS-1:0] wr_data,
    input  logic [1:0]                                    wr_count,
    output logic                                          has_room,
    output logic                                          head_valid,
    output udqs_pkg::result_t                             head,
    input  logic                                          pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(DEPTH - udqs_pkg::MAX_RESULTS);

    udqs_pkg::result_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] slot [udqs_pkg::MAX_RESULTS];
    logic             do_pop;

    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                 input logic [1:0] k);
        logic [PTR_W+1:0] s;
        begin
            s = {2'b00, p} + {{PTR_W{1'b0}}, k};
            if (s >= (PTR_W+2)'(DEPTH))
            begin
                s = s - (PTR_W+2)'(DEPTH);
            end
            return s[PTR_W-1:0];
        end
    endfunction

    assign has_room = (count_reg <= ROOM_LIMIT);
    assign head_valid = (count_reg != '0);
    assign head = mem[rd_ptr_reg];
    assign do_pop = pop && head_valid;

    always_comb
    begin
        for (int k = 0; k < udqs_pkg::MAX_RESULTS; k++)
        begin
            slot[k] = ptr_add(wr_ptr_reg, 2'(k));
        end
        wr_ptr_next = ptr_add(wr_ptr_reg, wr_count);
        rd_ptr_next = do_pop ? ptr_add(rd_ptr_reg, 2'd1) : rd_ptr_reg;
        count_next = count_reg + CNT_W'(wr_count) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < udqs_pkg::MAX_RESULTS; k++)
        begin
            if (2'(k) < wr_count)
            begin
                mem[slot[k]] <= wr_data[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

### hw/rtl/url_decode_query_splitter_core.sv
// url_decode_query_splitter_core: one url byte per beat in, parse results out.
// output: an accepted byte's results are registered in the result queue and presented from its head.
// throughput: one byte per cycle while each byte yields at most one result and events.ready is high;
// a byte with several results stalls input until the result queue has room again.
// reset: parse state cleared, max_pairs set to 10, result queue empty.
// depends on udqs_pkg, udqs_ifs, udqs_parser, udqs_result_fifo
module url_decode_query_splitter_core #(
    parameter int FIFO_DEPTH = udqs_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    udqs_url_if.sink                        url,
    udqs_result_if.source                   events,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [udqs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [udqs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [udqs_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    logic [7:0] max_pairs_reg, max_pairs_next;
    logic       cfg_write;
    logic       take;
    logic       has_room;
    logic       head_valid;
    logic [1:0] res_count;

    udqs_pkg::result_t [udqs_pkg::MAX_RESULTS-1:0] res;
    udqs_pkg::result_t                             head;

    // register index is the word address
    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[udqs_pkg::APB_ADDR_W-1] == udqs_pkg::REG_MAX_PAIRS);
    assign max_pairs_next = cfg_write ? pwdata[7:0] : max_pairs_reg;
    assign prdata = (paddr[udqs_pkg::APB_ADDR_W-1] == udqs_pkg::REG_MAX_PAIRS)
                    ? {{(udqs_pkg::APB_DATA_W-8){1'b0}}, max_pairs_reg}
                    : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pairs_reg <= udqs_pkg::MAX_PAIRS_RESET;
        end
        else
        begin
            max_pairs_reg <= max_pairs_next;
        end
    end

    assign url.ready = has_room;
    assign take = url.valid && has_room;

    udqs_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .in_byte   (url.in_byte),
        .is_last   (url.is_last),
        .max_pairs (max_pairs_reg),
        .res       (res),
        .res_count (res_count)
    );

    udqs_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_data    (res),
        .wr_count   (take ? res_count : 2'd0),
        .has_room   (has_room),
        .head_valid (head_valid),
        .head       (head),
        .pop        (events.ready)
    );

    assign events.valid = head_valid;
    assign events.kind = head.kind;
    assign events.out_byte = head.out_byte;
    assign events.pair_index = head.pair_index;
    assign events.pairs_found = head.pairs_found;
    assign events.bad_escape = head.bad_escape;
    assign events.last = head.last;

endmodule
